@@ rtl/sed_pkg.sv @@
// shared types and constants for the string escape decoder
// used by every module of the block, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

	// one raw input transfer
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	// one decoded result transfer
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic [2:0] error_code;
		logic       last;
	} out_item_t;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_EOF_ESC = 3'd1;
	localparam logic [2:0] ERR_BAD_HEX = 3'd2;
	localparam logic [2:0] ERR_BAD_UNI = 3'd3;
	localparam logic [2:0] ERR_RANGE   = 3'd4;
	localparam logic [2:0] ERR_UNKNOWN = 3'd5;

	localparam int MAX_RES  = 4;
	localparam int RES_IDX_W = $clog2(MAX_RES);

	// one result slot of a command, without the last flag
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic [2:0] error_code;
	} res_t;

	// everything one input causes, handed from front to back
	typedef struct packed {
		logic [RES_IDX_W-1:0]   last_idx;
		res_t [MAX_RES-1:0]     res;
	} cmd_t;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// queue status seen by the back and by the top-level take logic
	typedef struct packed {
		logic full;
		logic avail;
	} q_stat_t;

endpackage

`default_nettype wire

@@ rtl/sed_front.sv @@
// front part: accepts raw bytes, tracks escape state and builds result commands
// depends on sed_pkg
`timescale 1ns / 1ps
`default_nettype none

module sed_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  sed_pkg::in_item_t   item,
	output logic                cmd_valid,
	output sed_pkg::cmd_t       cmd
);

	typedef enum logic [1:0] {
		M_NORMAL = 2'd0,
		M_ESCAPE = 2'd1,
		M_HEX    = 2'd2,
		M_UNI    = 2'd3
	} mode_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_UP_U   = 8'h55;

	localparam logic [31:0] CP_1B = 32'h7F;
	localparam logic [31:0] CP_2B = 32'h7FF;
	localparam logic [31:0] CP_3B = 32'hFFFF;
	localparam logic [31:0] CP_4B = 32'h10FFFF;

	mode_t       mode_q, mode_d;
	logic [3:0]  seen_q, seen_d;
	logic [3:0]  need_q, need_d;
	logic [31:0] acc_q, acc_d;

	function automatic sed_pkg::res_t mk(input logic [7:0] b, input logic h,
		input logic [2:0] e);
		sed_pkg::res_t r;
		r.out_byte   = b;
		r.has_byte   = h;
		r.error_code = e;
		return r;
	endfunction

	// returns {valid, nibble}
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [4:0] v;
		v = 5'd0;
		if (b >= 8'h30 && b <= 8'h39)
			v = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66)
			v = {1'b1, 4'(b - 8'h61 + 8'd10)};
		else if (b >= 8'h41 && b <= 8'h46)
			v = {1'b1, 4'(b - 8'h41 + 8'd10)};
		return v;
	endfunction

	// single-letter escapes, {known, byte}
	function automatic logic [8:0] letter(input logic [7:0] b);
		logic [8:0] v;
		case (b)
			8'h6E:   v = {1'b1, 8'h0A};
			8'h74:   v = {1'b1, 8'h09};
			8'h72:   v = {1'b1, 8'h0D};
			8'h5C:   v = {1'b1, 8'h5C};
			8'h27:   v = {1'b1, 8'h27};
			8'h22:   v = {1'b1, 8'h22};
			8'h30:   v = {1'b1, 8'h00};
			8'h61:   v = {1'b1, 8'h07};
			8'h62:   v = {1'b1, 8'h08};
			8'h66:   v = {1'b1, 8'h0C};
			8'h76:   v = {1'b1, 8'h0B};
			default: v = {1'b0, b};
		endcase
		return v;
	endfunction

	logic [7:0]  b;
	logic        eoi;
	logic [4:0]  hv;
	logic        is_hex;
	logic [31:0] acc_sh;
	logic [3:0]  seen_inc;
	logic [8:0]  lt;
	logic [2:0]  n;

	assign b        = item.in_byte;
	assign eoi      = item.end_of_input;
	assign hv       = hex_val(b);
	assign is_hex   = hv[4] && !eoi;
	assign acc_sh   = {acc_q[27:0], hv[3:0]};
	assign seen_inc = seen_q + 4'd1;
	assign lt       = letter(b);

	always_comb begin
		mode_d = mode_q;
		seen_d = seen_q;
		need_d = need_q;
		acc_d  = acc_q;
		n      = 3'd0;
		for (int i = 0; i < sed_pkg::MAX_RES; i++)
			cmd.res[i] = mk(8'h00, 1'b0, sed_pkg::ERR_NONE);

		case (mode_q)
			M_NORMAL: begin
				if (!eoi) begin
					if (b == CH_BSLASH) begin
						mode_d = M_ESCAPE;
					end else begin
						cmd.res[0] = mk(b, 1'b1, sed_pkg::ERR_NONE);
						n = 3'd1;
					end
				end
			end
			M_ESCAPE: begin
				mode_d = M_NORMAL;
				if (eoi) begin
					cmd.res[0] = mk(8'h00, 1'b0, sed_pkg::ERR_EOF_ESC);
					n = 3'd1;
				end else if (b == CH_X || b == CH_LOW_U || b == CH_UP_U) begin
					mode_d = (b == CH_X) ? M_HEX : M_UNI;
					seen_d = 4'd0;
					acc_d  = 32'd0;
					need_d = (b == CH_X) ? 4'd2 : ((b == CH_LOW_U) ? 4'd4 : 4'd8);
				end else if (lt[8]) begin
					cmd.res[0] = mk(lt[7:0], 1'b1, sed_pkg::ERR_NONE);
					n = 3'd1;
				end else begin
					cmd.res[0] = mk(b, 1'b1, sed_pkg::ERR_UNKNOWN);
					n = 3'd1;
				end
			end
			M_HEX, M_UNI: begin
				if (is_hex) begin
					acc_d  = acc_sh;
					seen_d = seen_inc;
					if (seen_inc >= need_q) begin
						mode_d = M_NORMAL;
						if (mode_q == M_HEX || acc_sh <= CP_1B) begin
							cmd.res[0] = mk(acc_sh[7:0], 1'b1, sed_pkg::ERR_NONE);
							n = 3'd1;
						end else if (acc_sh <= CP_2B) begin
							cmd.res[0] = mk({3'b110, acc_sh[10:6]}, 1'b1, sed_pkg::ERR_NONE);
							cmd.res[1] = mk({2'b10, acc_sh[5:0]}, 1'b1, sed_pkg::ERR_NONE);
							n = 3'd2;
						end else if (acc_sh <= CP_3B) begin
							cmd.res[0] = mk({4'b1110, acc_sh[15:12]}, 1'b1, sed_pkg::ERR_NONE);
							cmd.res[1] = mk({2'b10, acc_sh[11:6]}, 1'b1, sed_pkg::ERR_NONE);
							cmd.res[2] = mk({2'b10, acc_sh[5:0]}, 1'b1, sed_pkg::ERR_NONE);
							n = 3'd3;
						end else if (acc_sh <= CP_4B) begin
							cmd.res[0] = mk({5'b11110, acc_sh[20:18]}, 1'b1, sed_pkg::ERR_NONE);
							cmd.res[1] = mk({2'b10, acc_sh[17:12]}, 1'b1, sed_pkg::ERR_NONE);
							cmd.res[2] = mk({2'b10, acc_sh[11:6]}, 1'b1, sed_pkg::ERR_NONE);
							cmd.res[3] = mk({2'b10, acc_sh[5:0]}, 1'b1, sed_pkg::ERR_NONE);
							n = 3'd4;
						end else begin
							cmd.res[0] = mk(8'h00, 1'b0, sed_pkg::ERR_RANGE);
							n = 3'd1;
						end
					end
				end else begin
					// short escape: error or partial hex byte, then byte as plain input
					mode_d = M_NORMAL;
					if (mode_q == M_UNI)
						cmd.res[0] = mk(8'h00, 1'b0, sed_pkg::ERR_BAD_UNI);
					else if (seen_q == 4'd0)
						cmd.res[0] = mk(8'h00, 1'b0, sed_pkg::ERR_BAD_HEX);
					else
						cmd.res[0] = mk(acc_q[7:0], 1'b1, sed_pkg::ERR_NONE);
					n = 3'd1;
					if (!eoi) begin
						if (b == CH_BSLASH) begin
							mode_d = M_ESCAPE;
						end else begin
							cmd.res[1] = mk(b, 1'b1, sed_pkg::ERR_NONE);
							n = 3'd2;
						end
					end
				end
			end
			default: begin
				mode_d = M_NORMAL;
			end
		endcase

		cmd.last_idx = sed_pkg::RES_IDX_W'(n - 3'd1);
	end

	assign cmd_valid    = take && (n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			seen_q <= 4'd0;
			need_q <= 4'd0;
			acc_q  <= 32'd0;
		end else if (take) begin
			mode_q <= mode_d;
			seen_q <= seen_d;
			need_q <= need_d;
			acc_q  <= acc_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/sed_cmd_queue.sv @@
// short command queue between front and back
// depends on sed_pkg
`timescale 1ns / 1ps
`default_nettype none

module sed_cmd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  sed_pkg::cmd_t       wr_data,
	input  wire logic           rd_en,
	output sed_pkg::q_stat_t    stat,
	output sed_pkg::cmd_t       head
);

	sed_pkg::cmd_t                 mem_q [sed_pkg::QDEPTH];
	logic [sed_pkg::QPTR_W-1:0]    wptr_q, rptr_q;
	logic [sed_pkg::QCNT_W-1:0]    cnt_q;

	assign stat.full  = (cnt_q == sed_pkg::QCNT_W'(sed_pkg::QDEPTH));
	assign stat.avail = (cnt_q != '0);
	assign head       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en)
				wptr_q <= wptr_q + 1'b1;
			if (rd_en)
				rptr_q <= rptr_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/sed_back.sv @@
// back part: walks the results of each command into the output register
// depends on sed_pkg
`timescale 1ns / 1ps
`default_nettype none

module sed_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  sed_pkg::q_stat_t    stat,
	input  sed_pkg::cmd_t       head,
	output logic                rd_en,
	input  wire logic           pop,
	output logic                empty,
	output sed_pkg::out_item_t  result
);

	logic [sed_pkg::RES_IDX_W-1:0] idx_q;
	logic                          out_valid_q;
	sed_pkg::out_item_t            out_q;
	logic                          load;
	logic                          at_last;
	sed_pkg::res_t                 cur;

	// output register frees up when empty or being taken this cycle
	assign load    = stat.avail && (!out_valid_q || pop);
	assign at_last = (idx_q == head.last_idx);
	assign cur     = head.res[idx_q];
	assign rd_en   = load && at_last;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte   <= cur.out_byte;
			out_q.has_byte   <= cur.has_byte;
			out_q.error_code <= cur.error_code;
			out_q.last       <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= at_last ? '0 : idx_q + 1'b1;
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ rtl/string_escape_decoder_unit.sv @@
// Decodes string literal bodies byte by byte, expanding escapes and \u / \U code
// points to UTF-8. An input byte is taken whenever the four-entry command queue
// has room; the back end drains one result per cycle while the result side pops,
// and an input yields 0 to 4 results. Sustained throughput is one result per
// cycle while pop is held, set by the single output register; full rises when
// four commands wait in the queue, which happens when multi-byte results pile up
// or the result side stalls. The first result of an input is registered in the
// command queue and then in the output register. No clearing pass after reset.
// depends on sed_pkg, sed_front, sed_cmd_queue, sed_back
`timescale 1ns / 1ps
`default_nettype none

module string_escape_decoder_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  sed_pkg::in_item_t   item,
	output logic                empty,
	input  wire logic           pop,
	output sed_pkg::out_item_t  result
);

	sed_pkg::q_stat_t stat;
	sed_pkg::cmd_t    cmd;
	sed_pkg::cmd_t    head;
	logic             cmd_valid;
	logic             rd_en;
	logic             take;

	assign full = stat.full;
	assign take = push && !stat.full;

	sed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	sed_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (cmd),
		.rd_en   (rd_en),
		.stat    (stat),
		.head    (head)
	);

	sed_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.head   (head),
		.rd_en  (rd_en),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

`default_nettype wire
